@@ sv/character_octet_pixel_expander_assert.svh @@
// Assertion macros for the octet pixel expander checker.
// No dependencies; expects i_clk and i_rst_n in the using scope.
`ifndef CHARACTER_OCTET_PIXEL_EXPANDER_ASSERT_SVH
`define CHARACTER_OCTET_PIXEL_EXPANDER_ASSERT_SVH

// clocked, masked during reset
`define COPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked, also checked during reset
`define COPE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/cope_pkg.sv @@
// Shared types and constants for the octet pixel expander.
// No dependencies.
`default_nettype none
package cope_pkg;

    localparam int FIRST_LINE  = 16;
    localparam int END_LINE    = 300;
    localparam int LEFT_EDGE   = 0;
    localparam int ROW_OFFSET  = 100;

    localparam int PIXELS      = 8;
    localparam int K_W         = 3;
    localparam int ROW_W       = 10;
    localparam int WIDTH_W     = 12;
    localparam int PROD_W      = ROW_W + WIDTH_W;
    localparam int ADDR_W      = 32;
    localparam int COLOR_W     = 16;

    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [ADDR_W-1:0]  t_addr;

    typedef enum logic [2:0] {
        OP_HIRES_TEXT  = 3'd0,
        OP_EXTBG_TEXT  = 3'd1,
        OP_MULTI_TEXT  = 3'd2,
        OP_HIRES_BMP   = 3'd3,
        OP_MULTI_BMP   = 3'd4,
        OP_BORDER      = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        CFG_FRAME_BASE  = 3'd0,
        CFG_FRAME_WIDTH = 3'd1,
        CFG_BG_ZERO     = 3'd2,
        CFG_BG_ONE      = 3'd3,
        CFG_BG_TWO      = 3'd4,
        CFG_BG_THREE    = 3'd5
    } t_cfg_idx;

endpackage
`default_nettype wire

@@ sv/character_octet_pixel_expander.sv @@
// Octet pixel expander: one pattern byte in, eight framebuffer pixel writes out.
// Depends on cope_pkg.
`default_nettype none
// Each accepted octet on a visible line with a defined mode yields eight pixel
// beats, one per cycle while the output is not stalled, so the sustained octet
// rate is set by the single pixel output. The first beat appears once the octet
// has passed window check, row multiply and address and colour decode stages
// and been loaded into the pixel serialiser; up to three further octets queue in
// the pipeline while the output stalls. Octets on hidden lines or with undefined
// modes are dropped. Configuration is written through the cfg channel, which is
// always ready, and must only be written while the block is idle.
module character_octet_pixel_expander (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [2:0]             i_op,
    input  wire logic [8:0]             i_screen_x,
    input  wire logic [8:0]             i_screen_y,
    input  wire logic [7:0]             i_pattern,
    input  wire cope_pkg::t_color       i_fore_color,
    input  wire cope_pkg::t_color       i_color_a,
    input  wire cope_pkg::t_color       i_color_b,
    input  wire cope_pkg::t_color       i_color_c,
    input  wire logic [1:0]             i_bg_select,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output cope_pkg::t_addr             o_pixel_address,
    output cope_pkg::t_color            o_pixel_color,
    output logic                        o_last_pixel,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [2:0]             i_cfg_index,
    input  wire logic [31:0]            i_cfg_data
);
    import cope_pkg::*;

    localparam logic [K_W-1:0] LAST_K = K_W'(PIXELS - 1);

    // configuration
    t_addr                r_frame_base;
    logic [WIDTH_W-1:0]   r_frame_width;
    t_color               r_bg [4];

    // stage 1: window check, row
    logic                 r1_v;
    t_op                  r1_op;
    logic [8:0]           r1_x;
    logic [ROW_W-1:0]     r1_row;
    logic [7:0]           r1_pat;
    t_color               r1_fore, r1_ca, r1_cb, r1_cc;
    logic [1:0]           r1_sel;

    // stage 2: row product
    logic                 r2_v;
    t_op                  r2_op;
    logic [8:0]           r2_x;
    logic [PROD_W-1:0]    r2_prod;
    logic [7:0]           r2_pat;
    t_color               r2_fore, r2_ca, r2_cb, r2_cc;
    logic [1:0]           r2_sel;

    // stage 3: start address, colours
    logic                 r3_v;
    t_addr                r3_addr;
    t_color               r3_col [PIXELS];

    // serialiser
    logic                 r_sv;
    logic [K_W-1:0]       r_k;
    t_addr                r_addr;
    t_color               r_col [PIXELS];

    logic                 in_acc, keep, out_fire, ser_load, rdy3, rdy2, rdy1;
    logic [ROW_W-1:0]     n_row;
    t_addr                n_start, n_addr;
    t_color               n_col [PIXELS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base  <= '0;
            r_frame_width <= WIDTH_W'(640);
            for (int i = 0; i < 4; i++) r_bg[i] <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_BASE:  r_frame_base  <= i_cfg_data;
                CFG_FRAME_WIDTH: r_frame_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_BG_ZERO:     r_bg[0]       <= i_cfg_data[COLOR_W-1:0];
                CFG_BG_ONE:      r_bg[1]       <= i_cfg_data[COLOR_W-1:0];
                CFG_BG_TWO:      r_bg[2]       <= i_cfg_data[COLOR_W-1:0];
                CFG_BG_THREE:    r_bg[3]       <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    assign out_fire = r_sv && !i_stall;
    assign ser_load = !r_sv || (out_fire && (r_k == LAST_K));
    assign rdy3     = !r3_v || ser_load;
    assign rdy2     = !r2_v || rdy3;
    assign rdy1     = !r1_v || rdy2;
    assign o_stall  = !rdy1;
    assign in_acc   = i_valid && rdy1;

    assign keep  = (i_op <= 3'(OP_BORDER))
                && ({1'b0, i_screen_y} >= ROW_W'(FIRST_LINE))
                && ({1'b0, i_screen_y} <  ROW_W'(END_LINE));
    assign n_row = {1'b0, i_screen_y} - ROW_W'(FIRST_LINE) + ROW_W'(ROW_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (rdy1) begin
            r1_v <= in_acc && keep;
        end
        if (rdy1 && in_acc) begin
            r1_op   <= t_op'(i_op);
            r1_x    <= i_screen_x;
            r1_row  <= n_row;
            r1_pat  <= i_pattern;
            r1_fore <= i_fore_color;
            r1_ca   <= i_color_a;
            r1_cb   <= i_color_b;
            r1_cc   <= i_color_c;
            r1_sel  <= i_bg_select;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (rdy2) begin
            r2_v <= r1_v;
        end
        if (rdy2 && r1_v) begin
            r2_op   <= r1_op;
            r2_x    <= r1_x;
            r2_prod <= PROD_W'(r1_row) * PROD_W'(r_frame_width);
            r2_pat  <= r1_pat;
            r2_fore <= r1_fore;
            r2_ca   <= r1_ca;
            r2_cb   <= r1_cb;
            r2_cc   <= r1_cc;
            r2_sel  <= r1_sel;
        end
    end

    assign n_start = ADDR_W'(r2_prod) + ADDR_W'(r2_x) - ADDR_W'(LEFT_EDGE);
    assign n_addr  = r_frame_base + {n_start[ADDR_W-2:0], 1'b0};

    always_comb begin
        for (int k = 0; k < PIXELS; k++) begin
            logic       b;
            logic [1:0] p;
            b = r2_pat[PIXELS-1-k];
            p = r2_pat[PIXELS-1-2*(k/2) -: 2];
            unique case (r2_op)
                OP_HIRES_TEXT: n_col[k] = b ? r2_fore : r_bg[0];
                OP_EXTBG_TEXT: n_col[k] = b ? r2_fore : r_bg[r2_sel];
                OP_MULTI_TEXT: n_col[k] = (p == 2'b11) ? r2_fore : r_bg[p];
                OP_HIRES_BMP:  n_col[k] = b ? r2_cb : r2_ca;
                OP_MULTI_BMP: begin
                    unique case (p)
                        2'b00: n_col[k] = r_bg[0];
                        2'b01: n_col[k] = r2_ca;
                        2'b10: n_col[k] = r2_cb;
                        2'b11: n_col[k] = r2_cc;
                    endcase
                end
                default:       n_col[k] = r2_fore;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (rdy3) begin
            r3_v <= r2_v;
        end
        if (rdy3 && r2_v) begin
            r3_addr <= n_addr;
            r3_col  <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_k  <= '0;
        end else if (ser_load) begin
            r_sv <= r3_v;
            r_k  <= '0;
        end else if (out_fire) begin
            r_k  <= r_k + K_W'(1);
        end
        if (ser_load && r3_v) begin
            r_addr <= r3_addr;
            r_col  <= r3_col;
        end else if (!ser_load && out_fire) begin
            r_addr <= r_addr + ADDR_W'(2);
        end
    end

    assign o_valid         = r_sv;
    assign o_pixel_address = r_addr;
    assign o_pixel_color   = r_col[r_k];
    assign o_last_pixel    = (r_k == LAST_K);

endmodule
`default_nettype wire

@@ sv/cope_checker.sv @@
// Port-level checker for the octet pixel expander, bound to the top level.
// Depends on cope_pkg and character_octet_pixel_expander_assert.svh.
`default_nettype none
`include "character_octet_pixel_expander_assert.svh"
module cope_checker (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   o_valid,
    input  wire logic                   i_stall,
    input  wire cope_pkg::t_addr        o_pixel_address,
    input  wire cope_pkg::t_color       o_pixel_color,
    input  wire logic                   o_last_pixel
);
    import cope_pkg::*;

    `COPE_ASSERT(a_beat_holds, o_valid && i_stall |=> o_valid, "output beat dropped while stalled")
    `COPE_ASSERT(a_payload_holds, o_valid && i_stall |=> $stable(o_pixel_address) && $stable(o_pixel_color) && $stable(o_last_pixel), "stalled beat changed")
    `COPE_ASSERT(a_octet_runs, o_valid && !i_stall && !o_last_pixel |=> o_valid && (o_pixel_address == $past(o_pixel_address) + ADDR_W'(2)), "octet beats not contiguous")
    `COPE_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_valid, "beat offered after reset")

endmodule

bind character_octet_pixel_expander cope_checker u_cope_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_pixel_address (o_pixel_address),
    .o_pixel_color   (o_pixel_color),
    .o_last_pixel    (o_last_pixel)
);
`default_nettype wire

@@ sim/tb_character_octet_pixel_expander.sv @@
`timescale 1ns / 1ps
// Testbench for character_octet_pixel_expander: directed and random octets, each pixel
// beat checked against a behavioural model of the expander. Depends on cope_pkg.
module tb_character_octet_pixel_expander;
    import cope_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 16;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 80;

    localparam logic [2:0] OP_SPARE_SIX    = 3'd6;
    localparam logic [2:0] OP_SPARE_SEVEN  = 3'd7;
    localparam logic [2:0] CFG_SPARE_SIX   = 3'd6;
    localparam logic [2:0] CFG_SPARE_SEVEN = 3'd7;

    typedef struct {
        logic [2:0] op;
        logic [8:0] x;
        logic [8:0] y;
        logic [7:0] pattern;
        t_color     fore;
        t_color     ca;
        t_color     cb;
        t_color     cc;
        logic [1:0] sel;
    } t_octet;

    typedef struct {
        t_addr  addr;
        t_color colour;
        logic   last;
    } t_pixel_write;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_op;
    logic [8:0]  i_screen_x;
    logic [8:0]  i_screen_y;
    logic [7:0]  i_pattern;
    t_color      i_fore_color;
    t_color      i_color_a;
    t_color      i_color_b;
    t_color      i_color_c;
    logic [1:0]  i_bg_select;
    logic        o_valid;
    logic        i_stall;
    t_addr       o_pixel_address;
    t_color      o_pixel_color;
    logic        o_last_pixel;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    t_addr        frame_base_model;
    logic [11:0]  frame_width_model;
    t_color       bg_model [4];
    t_pixel_write pixel_writes_due [$];

    int          mismatches;
    int          cycle_count;
    int unsigned stall_left;
    bit          idling_on;
    logic        rx_hold;
    event        start_rx_hold;

    character_octet_pixel_expander uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_screen_x      (i_screen_x),
        .i_screen_y      (i_screen_y),
        .i_pattern       (i_pattern),
        .i_fore_color    (i_fore_color),
        .i_color_a       (i_color_a),
        .i_color_b       (i_color_b),
        .i_color_c       (i_color_c),
        .i_bg_select     (i_bg_select),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_pixel    (o_last_pixel),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    function automatic t_color pair_colour(input logic [1:0] pr, input t_color c0,
                                           input t_color c1, input t_color c2,
                                           input t_color c3);
        case (pr)
            2'd0:    return c0;
            2'd1:    return c1;
            2'd2:    return c2;
            default: return c3;
        endcase
    endfunction

    task automatic predict_octet_writes(input t_octet o);
        t_addr        row;
        t_addr        start;
        t_color       colour;
        logic [1:0]   pr;
        logic         b;
        t_pixel_write w;
        if (o.op > OP_BORDER) return;
        if (o.y < FIRST_LINE || o.y >= END_LINE) return;
        row   = t_addr'(o.y) - t_addr'(FIRST_LINE) + t_addr'(ROW_OFFSET);
        start = row * t_addr'(frame_width_model) + t_addr'(o.x) - t_addr'(LEFT_EDGE);
        for (int k = 0; k < PIXELS; k++) begin
            b  = o.pattern[7-k];
            pr = 2'(o.pattern >> (6 - 2 * (k / 2)));
            case (o.op)
                OP_HIRES_TEXT: colour = b ? o.fore : bg_model[0];
                OP_EXTBG_TEXT: colour = b ? o.fore : bg_model[o.sel];
                OP_MULTI_TEXT: colour = pair_colour(pr, bg_model[0], bg_model[1],
                                                    bg_model[2], o.fore);
                OP_HIRES_BMP:  colour = b ? o.cb : o.ca;
                OP_MULTI_BMP:  colour = pair_colour(pr, bg_model[0], o.ca, o.cb, o.cc);
                default:       colour = o.fore;
            endcase
            w.addr   = frame_base_model + t_addr'(2) * (start + t_addr'(k));
            w.colour = colour;
            w.last   = (k == PIXELS - 1);
            pixel_writes_due.push_back(w);
        end
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_FRAME_BASE:  frame_base_model  = data;
            CFG_FRAME_WIDTH: frame_width_model = data[11:0];
            CFG_BG_ZERO:     bg_model[0]       = data[15:0];
            CFG_BG_ONE:      bg_model[1]       = data[15:0];
            CFG_BG_TWO:      bg_model[2]       = data[15:0];
            CFG_BG_THREE:    bg_model[3]       = data[15:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_setting(input logic [31:0] base, input logic [31:0] width);
        write_register(CFG_FRAME_BASE, base);
        write_register(CFG_FRAME_WIDTH, width);
        write_register(CFG_BG_ZERO, $urandom);
        write_register(CFG_BG_ONE, $urandom);
        write_register(CFG_BG_TWO, $urandom);
        write_register(CFG_BG_THREE, $urandom);
    endtask

    // valid stays high across back-to-back beats; only lowered ahead of a gap
    task automatic send_octet(input t_octet o);
        int unsigned gap;
        gap = idling_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= o.op;
        i_screen_x   <= o.x;
        i_screen_y   <= o.y;
        i_pattern    <= o.pattern;
        i_fore_color <= o.fore;
        i_color_a    <= o.ca;
        i_color_b    <= o.cb;
        i_color_c    <= o.cc;
        i_bg_select  <= o.sel;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_octet_writes(o);
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (pixel_writes_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_octet make_octet(input logic [2:0] op, input logic [8:0] x,
                                          input logic [8:0] y, input logic [7:0] pattern,
                                          input logic [1:0] sel);
        t_octet o;
        o.op      = op;
        o.x       = x;
        o.y       = y;
        o.pattern = pattern;
        o.fore    = 16'hFFFF;
        o.ca      = 16'h0000;
        o.cb      = 16'h5A5A;
        o.cc      = 16'hA5A5;
        o.sel     = sel;
        return o;
    endfunction

    function automatic t_octet random_octet(input bit visible_only);
        t_octet o;
        if (!visible_only && $urandom_range(0, 19) == 0)
            o.op = 3'($urandom_range(OP_SPARE_SIX, OP_SPARE_SEVEN));
        else
            o.op = 3'($urandom_range(OP_HIRES_TEXT, OP_BORDER));
        if (visible_only || $urandom_range(0, 99) < 85)
            o.y = 9'($urandom_range(FIRST_LINE, END_LINE - 1));
        else
            o.y = 9'($urandom_range(0, 511));
        o.x       = 9'($urandom_range(0, 511));
        o.pattern = 8'($urandom);
        o.fore    = 16'($urandom);
        o.ca      = 16'($urandom);
        o.cb      = 16'($urandom);
        o.cc      = 16'($urandom);
        o.sel     = 2'($urandom);
        return o;
    endfunction

    always @(posedge i_clk) begin : pixel_sink
        int unsigned  wait_cycles;
        t_pixel_write due;
        wait_cycles = stall_left;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_writes_due.size() == 0) begin
                $display("%0t: no beat expected, got addr %h colour %h last %b",
                         $time, o_pixel_address, o_pixel_color, o_last_pixel);
                mismatches++;
            end else begin
                due = pixel_writes_due.pop_front();
                if (o_pixel_address !== due.addr) begin
                    $display("%0t: pixel_address expected %h got %h",
                             $time, due.addr, o_pixel_address);
                    mismatches++;
                end
                if (o_pixel_color !== due.colour) begin
                    $display("%0t: pixel_color expected %h got %h",
                             $time, due.colour, o_pixel_color);
                    mismatches++;
                end
                if (o_last_pixel !== due.last) begin
                    $display("%0t: last_pixel expected %b got %b",
                             $time, due.last, o_last_pixel);
                    mismatches++;
                end
            end
            wait_cycles = idling_on ? $urandom_range(0, 3) : 0;
        end
        if (rx_hold) begin
            i_stall <= 1'b1;
        end else if (wait_cycles > 0) begin
            i_stall    <= 1'b1;
            stall_left <= wait_cycles - 1;
        end else begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end
    end

    // long receiver hold-off, counted here
    initial begin
        rx_hold <= 1'b0;
        forever begin
            @(start_rx_hold);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic test_reset_values();
        send_octet(make_octet(OP_HIRES_TEXT, 9'd0, 9'd16, 8'hA5, 2'd0));
        send_octet(make_octet(OP_MULTI_TEXT, 9'd511, 9'd299, 8'h1B, 2'd0));
        send_octet(make_octet(OP_EXTBG_TEXT, 9'd7, 9'd100, 8'h3C, 2'd3));
        send_octet(make_octet(OP_BORDER, 9'd300, 9'd200, 8'h00, 2'd0));
        wait_until_drained();
    endtask

    task automatic test_directed_modes();
        write_register(CFG_FRAME_BASE, 32'hFFFF_FF00);
        write_register(CFG_FRAME_WIDTH, 32'd4095);
        write_register(CFG_BG_ZERO, 32'h0000_0000);
        write_register(CFG_BG_ONE, 32'h0000_FFFF);
        write_register(CFG_BG_TWO, 32'h0000_1234);
        write_register(CFG_BG_THREE, 32'hFFFF_ABCD);
        write_register(CFG_SPARE_SIX, 32'hFFFF_FFFF);
        write_register(CFG_SPARE_SEVEN, 32'h0000_0000);
        send_octet(make_octet(OP_HIRES_TEXT, 9'd0, 9'd16, 8'hFF, 2'd0));
        send_octet(make_octet(OP_HIRES_TEXT, 9'd511, 9'd299, 8'h00, 2'd0));
        for (int s = 0; s < 4; s++)
            send_octet(make_octet(OP_EXTBG_TEXT, 9'd64, 9'd128, 8'h0F, s[1:0]));
        send_octet(make_octet(OP_MULTI_TEXT, 9'd100, 9'd200, 8'h1B, 2'd0));
        send_octet(make_octet(OP_MULTI_TEXT, 9'd192, 9'd17, 8'hC0, 2'd0));
        send_octet(make_octet(OP_HIRES_BMP, 9'd128, 9'd64, 8'h80, 2'd0));
        send_octet(make_octet(OP_HIRES_BMP, 9'd1, 9'd298, 8'hA5, 2'd0));
        send_octet(make_octet(OP_MULTI_BMP, 9'd255, 9'd150, 8'h1B, 2'd0));
        send_octet(make_octet(OP_MULTI_BMP, 9'd256, 9'd151, 8'hE4, 2'd0));
        send_octet(make_octet(OP_BORDER, 9'd511, 9'd150, 8'h5A, 2'd0));
        // hidden lines either side of the window, then the two undefined modes
        send_octet(make_octet(OP_BORDER, 9'd10, 9'd15, 8'hFF, 2'd0));
        send_octet(make_octet(OP_HIRES_TEXT, 9'd10, 9'd300, 8'hFF, 2'd0));
        send_octet(make_octet(OP_MULTI_BMP, 9'd0, 9'd0, 8'hFF, 2'd0));
        send_octet(make_octet(OP_HIRES_BMP, 9'd511, 9'd511, 8'hFF, 2'd0));
        send_octet(make_octet(OP_SPARE_SIX, 9'd20, 9'd100, 8'hFF, 2'd1));
        send_octet(make_octet(OP_SPARE_SEVEN, 9'd30, 9'd101, 8'h00, 2'd2));
        send_octet(make_octet(OP_HIRES_TEXT, 9'd2, 9'd20, 8'h81, 2'd0));
        wait_until_drained();
    endtask

    task automatic test_random_octets();
        logic [31:0] base;
        logic [31:0] width;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin base = 32'h0000_0000; width = 32'h0000_0000; end
                1:       begin base = 32'hFFFF_FFFF; width = 32'hFFFF_FFFF; end
                2:       begin base = $urandom;      width = $urandom;      end
                default: begin base = $urandom;      width = 32'd640;       end
            endcase
            program_setting(base, width);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idling_on = ((n / 20) % 3 != 2);
                send_octet(random_octet(1'b0));
            end
            wait_until_drained();
        end
        idling_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        idling_on = 1'b0;
        -> start_rx_hold;
        for (int n = 0; n < 12; n++)
            send_octet(random_octet(1'b1));
        wait_until_drained();
        idling_on = 1'b1;
    endtask

    task automatic test_pause_and_resume();
        for (int n = 0; n < 6; n++)
            send_octet(random_octet(1'b0));
        wait_until_drained();
        for (int n = 0; n < 6; n++)
            send_octet(random_octet(1'b0));
        wait_until_drained();
    endtask

    initial begin
        mismatches        = 0;
        stall_left        = 0;
        idling_on         = 1'b1;
        frame_base_model  = '0;
        frame_width_model = 12'd640;
        for (int i = 0; i < 4; i++) bg_model[i] = '0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_stall      <= 1'b0;
        i_op         <= OP_HIRES_TEXT;
        i_screen_x   <= '0;
        i_screen_y   <= '0;
        i_pattern    <= '0;
        i_fore_color <= '0;
        i_color_a    <= '0;
        i_color_b    <= '0;
        i_color_c    <= '0;
        i_bg_select  <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_FRAME_BASE;
        i_cfg_data   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_directed_modes();
        test_random_octets();
        test_output_backpressure();
        test_pause_and_resume();

        wait_until_drained();
        if (mismatches == 0 && pixel_writes_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
